[hw/rtl/bertlv_pkg.sv]
package bertlv_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 8;

    localparam logic [2:0] PH_IDENT     = 3'd0;
    localparam logic [2:0] PH_LEN_FIRST = 3'd1;
    localparam logic [2:0] PH_LEN_MORE  = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;
    localparam logic [2:0] PH_DROP      = 3'd4;

    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_LEN   = 3'd1;
    localparam logic [2:0] K_VALUE = 3'd2;
    localparam logic [2:0] K_ERROR = 3'd3;
    localparam logic [2:0] K_DROP  = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_COUNT = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [7:0] LENGTH_MASK   = 8'h7F;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  held_id;
        logic [63:0] len_acc;
        logic [63:0] value_left;
    } t_state;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  identifier;
        logic [63:0] element_length;
        logic [7:0]  value_byte;
        logic        element_done;
        logic [1:0]  error_code;
    } t_result;

endpackage

[hw/rtl/bertlv_step.sv]
module bertlv_step #(
    parameter int MAX_LENGTH_BYTES = bertlv_pkg::MAX_LENGTH_BYTES_DEF,
    parameter int CNT_W            = $clog2(MAX_LENGTH_BYTES + 1)
) (
    input  logic [7:0]          i_data_byte,
    input  logic                i_buffer_end,
    input  bertlv_pkg::t_state  i_state,
    input  logic [CNT_W-1:0]    i_len_left,
    output bertlv_pkg::t_state  o_state,
    output logic [CNT_W-1:0]    o_len_left,
    output bertlv_pkg::t_result o_result
);

    logic [6:0]  count;
    logic [63:0] acc_shift;
    logic [63:0] acc_short;
    logic [63:0] value_dec;
    logic [CNT_W-1:0] cnt_dec;
    logic        report_id;

    assign count     = 7'(i_data_byte & bertlv_pkg::LENGTH_MASK);
    assign acc_shift = {i_state.len_acc[55:0], i_data_byte};
    assign acc_short = {57'd0, count};
    assign value_dec = i_state.value_left - 64'd1;
    assign cnt_dec   = i_len_left - CNT_W'(1);

    always_comb begin
        o_state    = i_state;
        o_len_left = i_len_left;
        report_id  = 1'b1;
        o_result.byte_kind      = bertlv_pkg::K_DROP;
        o_result.element_length = 64'd0;
        o_result.value_byte     = 8'd0;
        o_result.element_done   = 1'b0;
        o_result.error_code     = bertlv_pkg::ERR_NONE;

        case (i_state.phase)
            bertlv_pkg::PH_IDENT: begin
                o_state.held_id    = i_data_byte;
                o_result.byte_kind = bertlv_pkg::K_IDENT;
                o_state.phase      = bertlv_pkg::PH_LEN_FIRST;
            end
            bertlv_pkg::PH_LEN_FIRST: begin
                o_result.byte_kind = bertlv_pkg::K_LEN;
                if ((i_data_byte & bertlv_pkg::LONG_FORM_BIT) == 8'd0) begin
                    o_state.len_acc         = acc_short;
                    o_state.value_left      = acc_short;
                    o_result.element_length = acc_short;
                    if (count == 7'd0) begin
                        o_state.phase         = bertlv_pkg::PH_IDENT;
                        o_result.element_done = 1'b1;
                    end else begin
                        o_state.phase = bertlv_pkg::PH_VALUE;
                    end
                end else if (count == 7'd0 || count > 7'(MAX_LENGTH_BYTES)) begin
                    o_result.byte_kind  = bertlv_pkg::K_ERROR;
                    o_result.error_code = bertlv_pkg::ERR_BAD_COUNT;
                    o_state.phase       = bertlv_pkg::PH_DROP;
                end else begin
                    o_len_left      = CNT_W'(count);
                    o_state.len_acc = 64'd0;
                    o_state.phase   = bertlv_pkg::PH_LEN_MORE;
                end
            end
            bertlv_pkg::PH_LEN_MORE: begin
                o_result.byte_kind = bertlv_pkg::K_LEN;
                o_state.len_acc    = acc_shift;
                o_len_left         = cnt_dec;
                if (cnt_dec == '0) begin
                    o_result.element_length = acc_shift;
                    o_state.value_left      = acc_shift;
                    if (acc_shift == 64'd0) begin
                        o_state.phase         = bertlv_pkg::PH_IDENT;
                        o_result.element_done = 1'b1;
                    end else begin
                        o_state.phase = bertlv_pkg::PH_VALUE;
                    end
                end
            end
            bertlv_pkg::PH_VALUE: begin
                o_result.byte_kind      = bertlv_pkg::K_VALUE;
                o_result.element_length = i_state.len_acc;
                o_result.value_byte     = i_data_byte;
                o_state.value_left      = value_dec;
                if (value_dec == 64'd0) begin
                    o_result.element_done = 1'b1;
                    o_state.phase         = bertlv_pkg::PH_IDENT;
                end
            end
            default: begin
                report_id = 1'b0;
            end
        endcase

        if (i_buffer_end) begin
            if (o_result.byte_kind != bertlv_pkg::K_DROP
                    && o_result.byte_kind != bertlv_pkg::K_ERROR
                    && !o_result.element_done) begin
                o_result.byte_kind  = bertlv_pkg::K_ERROR;
                o_result.error_code = bertlv_pkg::ERR_TRUNCATED;
            end
            o_state.phase = bertlv_pkg::PH_IDENT;
        end

        o_result.identifier = report_id ? o_state.held_id : 8'd0;
    end

endmodule

[hw/rtl/ber_tlv_stream_parser.sv]
// a result is valid once its byte has passed the input register and then the result register
// throughput: one byte per cycle unless output stalls; the parse state updates once per byte
// both registers advance whenever the result register is empty or being taken
// reset: synchronous active-low i_rst_n empties both stages and returns the parser to
// expecting an identifier with all held state cleared
module ber_tlv_stream_parser #(
    parameter int MAX_LENGTH_BYTES = bertlv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_byte_kind,
    output logic [7:0]  o_identifier,
    output logic [63:0] o_element_length,
    output logic [7:0]  o_value_byte,
    output logic        o_element_done,
    output logic [1:0]  o_error_code
);

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    logic               r_in_valid;
    logic [7:0]         r_data_byte;
    logic               r_buffer_end;
    logic               r_out_valid;
    bertlv_pkg::t_result r_result;
    bertlv_pkg::t_state  r_state;
    logic [CNT_W-1:0]   r_len_left;

    bertlv_pkg::t_state  n_state;
    logic [CNT_W-1:0]   n_len_left;
    bertlv_pkg::t_result n_result;

    logic advance;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    bertlv_step #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
        .CNT_W(CNT_W)
    ) u_step (
        .i_data_byte(r_data_byte),
        .i_buffer_end(r_buffer_end),
        .i_state(r_state),
        .i_len_left(r_len_left),
        .o_state(n_state),
        .o_len_left(n_len_left),
        .o_result(n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.phase     <= bertlv_pkg::PH_IDENT;
            r_state.held_id   <= 8'd0;
            r_state.len_acc   <= 64'd0;
            r_state.value_left <= 64'd0;
            r_len_left        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state    <= n_state;
                    r_len_left <= n_len_left;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data_byte  <= i_data_byte;
            r_buffer_end <= i_buffer_end;
        end
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_kind      = r_result.byte_kind;
    assign o_identifier     = r_result.identifier;
    assign o_element_length = r_result.element_length;
    assign o_value_byte     = r_result.value_byte;
    assign o_element_done   = r_result.element_done;
    assign o_error_code     = r_result.error_code;

`ifndef NO_ASSERTIONS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind == bertlv_pkg::K_ERROR |-> o_error_code != bertlv_pkg::ERR_NONE)
        else $error("error result without error code");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind != bertlv_pkg::K_ERROR |-> o_error_code == bertlv_pkg::ERR_NONE)
        else $error("error code on non-error result");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_element_done
            |-> o_byte_kind == bertlv_pkg::K_LEN || o_byte_kind == bertlv_pkg::K_VALUE)
        else $error("element done on wrong byte kind");

    a_drop_state_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_state.phase == bertlv_pkg::PH_DROP |-> n_result.identifier == 8'd0)
        else $error("dropped byte reports an identifier");
`endif

endmodule

[tb/ber_tlv_stream_parser_test.sv]
module ber_tlv_stream_parser_test;

    localparam int MAX_LEN_BYTES = bertlv_pkg::MAX_LENGTH_BYTES_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 115;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        in_valid     = 1'b0;
    logic [7:0]  data_r       = 8'd0;
    logic        end_r        = 1'b0;
    logic        out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_identifier;
    logic [63:0] o_element_length;
    logic [7:0]  o_value_byte;
    logic        o_element_done;
    logic [1:0]  o_error_code;

    t_item               pending_q[$];
    bertlv_pkg::t_result expected_q[$];
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    logic        hold_arm     = 1'b0;
    logic        hold_active;
    int          hold_count   = 0;
    int          mismatches   = 0;
    int          pushed       = 0;

    logic [2:0]  ps_phase     = bertlv_pkg::PH_IDENT;
    logic [7:0]  ps_held_id   = 8'd0;
    logic [3:0]  ps_len_left  = 4'd0;
    logic [63:0] ps_len_acc   = 64'd0;
    logic [63:0] ps_value_left = 64'd0;

    ber_tlv_stream_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (data_r),
        .i_buffer_end     (end_r),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_byte_kind      (o_byte_kind),
        .o_identifier     (o_identifier),
        .o_element_length (o_element_length),
        .o_value_byte     (o_value_byte),
        .o_element_done   (o_element_done),
        .o_error_code     (o_error_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic finish_length();
        ps_value_left = ps_len_acc;
        if (ps_len_acc == 64'd0) begin
            ps_phase = bertlv_pkg::PH_IDENT;
            return 1'b1;
        end
        ps_phase = bertlv_pkg::PH_VALUE;
        return 1'b0;
    endfunction

    function automatic bertlv_pkg::t_result parse_byte(input logic [7:0] b, input logic last);
        bertlv_pkg::t_result r;
        logic [6:0] cnt;
        logic       report_id;
        r = '0;
        r.byte_kind = bertlv_pkg::K_DROP;
        report_id = 1'b1;
        case (ps_phase)
            bertlv_pkg::PH_IDENT: begin
                ps_held_id = b;
                r.byte_kind = bertlv_pkg::K_IDENT;
                ps_phase = bertlv_pkg::PH_LEN_FIRST;
            end
            bertlv_pkg::PH_LEN_FIRST: begin
                r.byte_kind = bertlv_pkg::K_LEN;
                if ((b & bertlv_pkg::LONG_FORM_BIT) == 8'd0) begin
                    ps_len_acc = {56'd0, b & bertlv_pkg::LENGTH_MASK};
                    r.element_length = ps_len_acc;
                    r.element_done = finish_length();
                end else begin
                    cnt = b[6:0];
                    if (cnt == 7'd0 || cnt > 7'(MAX_LEN_BYTES)) begin
                        r.byte_kind = bertlv_pkg::K_ERROR;
                        r.error_code = bertlv_pkg::ERR_BAD_COUNT;
                        ps_phase = bertlv_pkg::PH_DROP;
                    end else begin
                        ps_len_left = cnt[3:0];
                        ps_len_acc = 64'd0;
                        ps_phase = bertlv_pkg::PH_LEN_MORE;
                    end
                end
            end
            bertlv_pkg::PH_LEN_MORE: begin
                r.byte_kind = bertlv_pkg::K_LEN;
                ps_len_acc = {ps_len_acc[55:0], b};
                ps_len_left = ps_len_left - 4'd1;
                if (ps_len_left == 4'd0) begin
                    r.element_length = ps_len_acc;
                    r.element_done = finish_length();
                end
            end
            bertlv_pkg::PH_VALUE: begin
                r.byte_kind = bertlv_pkg::K_VALUE;
                r.element_length = ps_len_acc;
                r.value_byte = b;
                ps_value_left = ps_value_left - 64'd1;
                if (ps_value_left == 64'd0) begin
                    r.element_done = 1'b1;
                    ps_phase = bertlv_pkg::PH_IDENT;
                end
            end
            default: begin
                report_id = 1'b0;
            end
        endcase
        if (last) begin
            if (r.byte_kind != bertlv_pkg::K_DROP && r.byte_kind != bertlv_pkg::K_ERROR
                    && !r.element_done) begin
                r.byte_kind = bertlv_pkg::K_ERROR;
                r.error_code = bertlv_pkg::ERR_TRUNCATED;
            end
            ps_phase = bertlv_pkg::PH_IDENT;
        end
        r.identifier = report_id ? ps_held_id : 8'd0;
        return r;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic last);
        t_item it;
        it.data = b;
        it.last = last;
        pending_q.insert(pending_q.size(), it);
        pushed++;
    endtask

    task automatic gen_buffer();
        t_item       elem_q[$];
        int          n_elem;
        int          sel;
        int          nlen;
        int          cut;
        logic [63:0] len;
        logic        closed;
        t_item       it;
        n_elem = $urandom_range(1, 3);
        closed = 1'b0;
        it.last = 1'b0;
        for (int e = 0; e < n_elem && !closed; e++) begin
            sel = $urandom_range(0, 99);
            it.data = 8'($urandom_range(0, 255));
            elem_q.insert(elem_q.size(), it);
            len = 64'd0;
            if (sel < 50) begin
                len = (sel < 5) ? 64'd127 >> $urandom_range(0, 3) : 64'($urandom_range(0, 8));
                it.data = len[7:0];
                elem_q.insert(elem_q.size(), it);
            end else if (sel < 84 || sel >= 96) begin
                nlen = $urandom_range(1, MAX_LEN_BYTES);
                if (sel < 80) begin
                    len = 64'($urandom_range(0, 10));
                end else if (sel < 84) begin
                    nlen = $urandom_range(2, MAX_LEN_BYTES);
                    len = 64'($urandom_range(128, 200));
                end else begin
                    nlen = MAX_LEN_BYTES;
                    len = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
                    closed = 1'b1;
                end
                it.data = bertlv_pkg::LONG_FORM_BIT | 8'(nlen);
                elem_q.insert(elem_q.size(), it);
                for (int k = nlen - 1; k >= 0; k--) begin
                    it.data = 8'(len >> (8 * k));
                    elem_q.insert(elem_q.size(), it);
                end
                if (closed) begin
                    len = 64'($urandom_range(0, 4));
                end
            end else begin
                it.data = $urandom_range(0, 1) ? bertlv_pkg::LONG_FORM_BIT
                                               : 8'($urandom_range(8'h89, 8'hFF));
                elem_q.insert(elem_q.size(), it);
                repeat ($urandom_range(0, 3)) begin
                    it.data = 8'($urandom_range(0, 255));
                    elem_q.insert(elem_q.size(), it);
                end
                closed = 1'b1;
            end
            for (int v = 0; v < int'(len); v++) begin
                it.data = 8'($urandom_range(0, 255));
                elem_q.insert(elem_q.size(), it);
            end
        end
        if ($urandom_range(0, 99) < 12 && elem_q.size() > 1) begin
            cut = $urandom_range(0, elem_q.size() - 2);
            while (elem_q.size() > cut + 1) begin
                void'(elem_q.pop_back());
            end
        end
        elem_q[elem_q.size() - 1].last = 1'b1;
        foreach (elem_q[i]) begin
            push_item(elem_q[i].data, elem_q[i].last);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic hold);
        int start;
        @(posedge i_clk);
        tx_idle_pct <= tx_pct;
        rx_stall_pct <= rx_pct;
        hold_arm <= hold;
        @(posedge i_clk);
        start = pushed;
        while (pushed - start < PHASE_ITEMS) begin
            gen_buffer();
        end
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_item nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_q.insert(expected_q.size(), parse_byte(data_r, end_r));
            end
            if (!in_valid || o_in_ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = pending_q.pop_front();
                    in_valid <= 1'b1;
                    data_r <= nxt.data;
                    end_r <= nxt.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    assign hold_active = hold_arm && (hold_count < HOLD_CYCLES);

    always @(posedge i_clk) begin : hold_proc
        if (!i_rst_n) begin
            hold_count <= 0;
        end else if (hold_active) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge i_clk) begin : watch_proc
        bertlv_pkg::t_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual kind %0d",
                             $time, o_byte_kind);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("byte_kind", 64'(want.byte_kind), 64'(o_byte_kind));
                    check_field("identifier", 64'(want.identifier), 64'(o_identifier));
                    check_field("element_length", want.element_length, o_element_length);
                    check_field("value_byte", 64'(want.value_byte), 64'(o_value_byte));
                    check_field("element_done", 64'(want.element_done), 64'(o_element_done));
                    check_field("error_code", 64'(want.error_code), 64'(o_error_code));
                end
            end
            if (hold_active) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length element, then long form with extreme bytes
        push_item(8'h00, 1'b0); push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0); push_item(8'h81, 1'b0); push_item(8'h02, 1'b0);
        push_item(8'h00, 1'b0); push_item(8'hFF, 1'b1);
        // eight length bytes of all ones, truncated on the first value byte
        push_item(8'h30, 1'b0); push_item(8'h88, 1'b0);
        repeat (8) push_item(8'hFF, 1'b0);
        push_item(8'h5A, 1'b1);
        // bad count of zero, dropped bytes up to buffer end
        push_item(8'hA5, 1'b0); push_item(8'h80, 1'b0);
        push_item(8'h12, 1'b0); push_item(8'h34, 1'b1);
        // truncation on the identifier
        push_item(8'h01, 1'b1);
        // bad count above the limit on the final byte
        push_item(8'h02, 1'b0); push_item(8'h89, 1'b1);
        // truncation inside the length bytes
        push_item(8'h7E, 1'b0); push_item(8'h82, 1'b0); push_item(8'h01, 1'b1);
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end

        run_phase(0, 0, 1'b0);
        run_phase(58, 0, 1'b0);
        run_phase(0, 58, 1'b0);
        run_phase(9, 9, 1'b0);
        run_phase(0, 0, 1'b1);

        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bertlv_pkg.sv
hw/rtl/bertlv_step.sv
hw/rtl/ber_tlv_stream_parser.sv
tb/ber_tlv_stream_parser_test.sv
